### rtl/core/bmsi_pkg.sv
package bmsi_pkg;

    // Prescaler reload value for one scanline
    localparam int LINE_CYCLES    = 341;
    localparam int CHR_BANK_COUNT = 8;
    localparam int PRG_BANK_COUNT = 3;
    // Divider for counter steps in cycle mode
    localparam int CYCLE_DIV      = 3;

    // Prescaler: stored width, working width and floor
    localparam int PS_W      = 12;
    localparam int PS_CALC_W = 14;
    localparam int PS_MIN    = -2048;

    // Command queue between front and back
    localparam int CMD_DEPTH = 2;
    localparam int CMD_PTR_W = (CMD_DEPTH > 1) ? $clog2(CMD_DEPTH) : 1;
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    localparam int CHR_IDX_W = $clog2(CHR_BANK_COUNT);
    localparam int PULSE_W   = 9;
    localparam int CYC_W     = 10;

    // Register pages, address bits 15:12
    localparam logic [3:0] PAGE_PRG_A = 4'h8;
    localparam logic [3:0] PAGE_PRG_B = 4'h9;
    localparam logic [3:0] PAGE_CHR_A = 4'hA;
    localparam logic [3:0] PAGE_CHR_B = 4'hB;
    localparam logic [3:0] PAGE_CHR_C = 4'hC;
    localparam logic [3:0] PAGE_CHR_D = 4'hD;
    localparam logic [3:0] PAGE_IRQ_A = 4'hE;
    localparam logic [3:0] PAGE_IRQ_B = 4'hF;

    localparam logic [7:0] PRG1_RESET = 8'hFE;
    localparam logic [7:0] PRG2_RESET = 8'hFE;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_PRG,
        OP_CHR,
        OP_SOUND,
        OP_MIRROR,
        OP_RELOAD,
        OP_CTRL,
        OP_ACK,
        OP_TICK
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [CHR_IDX_W-1:0] idx;
        logic [7:0]           data;
        logic [CYC_W-1:0]     cycles;
    } t_cmd;

    typedef struct packed {
        logic [7:0]         prg_low;
        logic [7:0]         prg_mid;
        logic [7:0]         prg_high;
        logic [31:0]        chr_lower;
        logic [31:0]        chr_upper;
        logic [1:0]         mirroring;
        logic [PULSE_W-1:0] pulses;
        logic               sound;
    } t_result;

    typedef enum logic [1:0] {
        ST_FETCH,
        ST_RUN,
        ST_OUT
    } t_state;

endpackage

### rtl/core/bmsi_front.sv
module bmsi_front
    import bmsi_pkg::*;
(
    input  logic        i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [9:0]  i_ppu_cycles,
    output t_cmd        o_cmd
);

    logic [3:0] page;
    logic       sub;

    assign page = i_address[15:12];
    assign sub  = i_address[3] | i_address[4];

    // Classify the incoming word into one back-end command
    always_comb begin
        o_cmd.op     = OP_NONE;
        o_cmd.idx    = '0;
        o_cmd.data   = i_data;
        o_cmd.cycles = i_ppu_cycles;
        if (i_kind == KIND_TICK) begin
            o_cmd.op = OP_TICK;
        end else begin
            case (page)
                PAGE_PRG_A: begin
                    o_cmd.op  = OP_PRG;
                    o_cmd.idx = sub ? CHR_IDX_W'(1) : CHR_IDX_W'(0);
                end
                PAGE_PRG_B: begin
                    if (sub) begin
                        o_cmd.op = OP_SOUND;
                    end else begin
                        o_cmd.op  = OP_PRG;
                        o_cmd.idx = CHR_IDX_W'(2);
                    end
                end
                PAGE_CHR_A, PAGE_CHR_B, PAGE_CHR_C, PAGE_CHR_D: begin
                    // two banks per page, pages A..D map to banks 0..7
                    o_cmd.op  = OP_CHR;
                    o_cmd.idx = {page[1:0] - 2'd2, sub};
                end
                PAGE_IRQ_A: begin
                    o_cmd.op = sub ? OP_RELOAD : OP_MIRROR;
                end
                PAGE_IRQ_B: begin
                    o_cmd.op = sub ? OP_ACK : OP_CTRL;
                end
                default: begin
                    o_cmd.op = OP_NONE;
                end
            endcase
        end
    end

endmodule

### rtl/core/bmsi_cmd_fifo.sv
module bmsi_cmd_fifo
    import bmsi_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd                 r_mem [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_CNT_W-1:0] r_count, n_count;
    logic                 do_push, do_pop;

    assign o_full  = (r_count == CMD_CNT_W'(CMD_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_push = i_push & ~o_full;
    assign do_pop  = i_pop & ~o_empty;

    // Pointer and fill count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

### rtl/core/bmsi_back.sv
module bmsi_back
    import bmsi_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_cfg_wdata,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    t_state                r_state, n_state;
    logic [7:0]            r_prg [PRG_BANK_COUNT];
    logic [7:0]            n_prg [PRG_BANK_COUNT];
    logic [7:0]            r_chr [CHR_BANK_COUNT];
    logic [7:0]            n_chr [CHR_BANK_COUNT];
    logic [1:0]            r_mirror, n_mirror;
    logic [1:0]            r_applied, n_applied;
    logic [7:0]            r_reload, n_reload;
    logic [2:0]            r_ctrl, n_ctrl;
    logic [7:0]            r_count, n_count;
    logic signed [PS_W-1:0] r_presc, n_presc;
    logic [CYC_W-1:0]      r_rem, n_rem;
    logic [PULSE_W-1:0]    r_pulses, n_pulses;
    logic                  r_sound, n_sound;
    logic                  r_chr_ram;
    t_result               r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [7:0]                  step_count;
    logic                        step_pulse;
    logic signed [PS_CALC_W-1:0] ps_diff, ps_wrap, ps_sel;
    logic [7:0]                  chr_masked [CHR_BANK_COUNT];

    assign o_empty  = ~r_out_valid;
    assign o_result = r_out;

    // One counter step: reload on 255 and count a pulse
    assign step_pulse = (r_count == 8'hFF);
    assign step_count = step_pulse ? r_reload : r_count + 8'd1;

    // Scanline prescaler: subtract, wrap once, floor at the minimum
    assign ps_diff = PS_CALC_W'(r_presc) - $signed({{(PS_CALC_W - CYC_W){1'b0}}, i_cmd.cycles});
    assign ps_wrap = ps_diff + PS_CALC_W'(LINE_CYCLES);
    assign ps_sel  = (ps_diff < 0) ? ps_wrap : ps_diff;

    // CHR mask for RAM carts
    always_comb begin
        for (int i = 0; i < CHR_BANK_COUNT; i++) begin
            chr_masked[i] = r_chr_ram ? {5'd0, r_chr[i][2:0]} : r_chr[i];
        end
    end

    // Sequencer: fetch and execute, iterate cycle-mode steps, emit result
    always_comb begin
        n_state     = r_state;
        n_prg       = r_prg;
        n_chr       = r_chr;
        n_mirror    = r_mirror;
        n_applied   = r_applied;
        n_reload    = r_reload;
        n_ctrl      = r_ctrl;
        n_count     = r_count;
        n_presc     = r_presc;
        n_rem       = r_rem;
        n_pulses    = r_pulses;
        n_sound     = r_sound;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_cmd_pop   = 1'b0;

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_FETCH: begin
                if (!i_cmd_empty) begin
                    o_cmd_pop = 1'b1;
                    n_pulses  = '0;
                    n_sound   = 1'b0;
                    n_state   = ST_OUT;
                    case (i_cmd.op)
                        OP_PRG: begin
                            n_prg[i_cmd.idx[1:0]] = i_cmd.data;
                            n_applied             = r_mirror;
                        end
                        OP_CHR: begin
                            n_chr[i_cmd.idx] = i_cmd.data;
                            n_applied        = r_mirror;
                        end
                        OP_SOUND: begin
                            n_sound = 1'b1;
                        end
                        OP_MIRROR: begin
                            n_mirror = i_cmd.data[1:0];
                        end
                        OP_RELOAD: begin
                            n_reload = i_cmd.data;
                        end
                        OP_CTRL: begin
                            n_ctrl = i_cmd.data[2:0];
                            if (i_cmd.data[1]) begin
                                n_count = r_reload;
                                n_presc = PS_W'(LINE_CYCLES);
                            end
                        end
                        OP_ACK: begin
                            n_ctrl = {r_ctrl[2], r_ctrl[0], r_ctrl[0]};
                        end
                        OP_TICK: begin
                            if (r_ctrl[1]) begin
                                if (!r_ctrl[2]) begin
                                    if (ps_sel < PS_CALC_W'(PS_MIN)) begin
                                        n_presc = PS_W'(PS_MIN);
                                    end else begin
                                        n_presc = ps_sel[PS_W-1:0];
                                    end
                                    if (ps_diff < 0) begin
                                        n_count  = step_count;
                                        n_pulses = {{(PULSE_W - 1){1'b0}}, step_pulse};
                                    end
                                end else begin
                                    n_rem   = i_cmd.cycles;
                                    n_state = ST_RUN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RUN: begin
                // step the counter while the remaining count is at least CYCLE_DIV
                if (r_rem >= CYC_W'(CYCLE_DIV)) begin
                    n_rem   = r_rem - CYC_W'(CYCLE_DIV);
                    n_count = step_count;
                    if (step_pulse) begin
                        n_pulses = r_pulses + 1'b1;
                    end
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!r_out_valid || i_pop) begin
                    n_out.prg_low   = r_prg[0];
                    n_out.prg_mid   = r_prg[1];
                    n_out.prg_high  = r_prg[2];
                    n_out.chr_lower = {chr_masked[3], chr_masked[2],
                                       chr_masked[1], chr_masked[0]};
                    n_out.chr_upper = {chr_masked[7], chr_masked[6],
                                       chr_masked[5], chr_masked[4]};
                    n_out.mirroring = r_applied;
                    n_out.pulses    = r_pulses;
                    n_out.sound     = r_sound;
                    n_out_valid     = 1'b1;
                    n_state         = ST_FETCH;
                end
            end
            default: begin
                n_state = ST_FETCH;
            end
        endcase
    end

    // Control and mapper state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_FETCH;
            r_prg[0]    <= 8'd0;
            r_prg[1]    <= PRG1_RESET;
            r_prg[2]    <= PRG2_RESET;
            for (int i = 0; i < CHR_BANK_COUNT; i++) begin
                r_chr[i] <= 8'd0;
            end
            r_mirror    <= '0;
            r_applied   <= '0;
            r_reload    <= '0;
            r_ctrl      <= '0;
            r_count     <= '0;
            r_presc     <= '0;
            r_chr_ram   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_prg       <= n_prg;
            r_chr       <= n_chr;
            r_mirror    <= n_mirror;
            r_applied   <= n_applied;
            r_reload    <= n_reload;
            r_ctrl      <= n_ctrl;
            r_count     <= n_count;
            r_presc     <= n_presc;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_chr_ram <= i_cfg_wdata;
            end
        end
    end

    // Per-word working values and result payload
    always_ff @(posedge i_clk) begin
        r_rem    <= n_rem;
        r_pulses <= n_pulses;
        r_sound  <= n_sound;
        r_out    <= n_out;
    end

endmodule

### rtl/core/bank_mapper_with_scanline_irq_core.sv
// Path: a pushed word is written to the command queue, fetched and executed
//   by the back end, then copied into the result register when the slot is free.
// The back end takes no new word until the last result is emitted; a cycle-mode
//   tick holds it longer while the sequencer steps the IRQ counter once a cycle.
// Reset: i_rst_n synchronous, active low; bank, IRQ and config registers take
//   their power-on values and the command queue and result slot are emptied.
module bank_mapper_with_scanline_irq_core
    import bmsi_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_kind,
    input  logic [15:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [9:0]  i_ppu_cycles,
    output logic        o_empty,
    input  logic        i_pop,
    output logic [7:0]  o_prg_bank_low,
    output logic [7:0]  o_prg_bank_mid,
    output logic [7:0]  o_prg_bank_high,
    output logic [31:0] o_chr_banks_lower,
    output logic [31:0] o_chr_banks_upper,
    output logic [1:0]  o_mirroring,
    output logic [8:0]  o_irq_pulses,
    output logic        o_sound_write
);

    t_cmd    front_cmd;
    t_cmd    queue_cmd;
    logic    queue_empty;
    logic    queue_pop;
    t_result result;

    // Decode incoming word
    bmsi_front u_front (
        .i_kind       (i_kind),
        .i_address    (i_address),
        .i_data       (i_data),
        .i_ppu_cycles (i_ppu_cycles),
        .o_cmd        (front_cmd)
    );

    // Queue between decode and execute
    bmsi_cmd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_cmd   (front_cmd),
        .o_full  (o_full),
        .i_pop   (queue_pop),
        .o_empty (queue_empty),
        .o_cmd   (queue_cmd)
    );

    // Execute and hold result
    bmsi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd_empty (queue_empty),
        .i_cmd       (queue_cmd),
        .o_cmd_pop   (queue_pop),
        .i_pop       (i_pop),
        .o_empty     (o_empty),
        .o_result    (result)
    );

    assign o_prg_bank_low    = result.prg_low;
    assign o_prg_bank_mid    = result.prg_mid;
    assign o_prg_bank_high   = result.prg_high;
    assign o_chr_banks_lower = result.chr_lower;
    assign o_chr_banks_upper = result.chr_upper;
    assign o_mirroring       = result.mirroring;
    assign o_irq_pulses      = result.pulses;
    assign o_sound_write     = result.sound;

endmodule
